// ----- hdl/pfba_pkg.sv -----
// Shared constants, types and helper functions for the page frame bitmap allocator.
`default_nettype none
package pfba_pkg;

    localparam int MAX_PAGES  = 4096;
    localparam int WORD_BITS  = 32;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WORDS      = MAX_PAGES / WORD_BITS;
    localparam int WIDX_W     = $clog2(WORDS);
    localparam int PAGE_W     = $clog2(MAX_PAGES);
    localparam int CNT_W      = PAGE_W + 1;
    localparam int POP_W      = BIT_W + 1;
    localparam int MAX_RANGES = 8;
    localparam int RIDX_W     = $clog2(MAX_RANGES);
    localparam int RCNT_W     = RIDX_W + 1;
    localparam int OP_W       = 2;
    localparam int STAT_W     = 2;
    localparam int PADDR_W    = 3;

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
    localparam logic [STAT_W-1:0] ST_FAIL = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    localparam logic REG_TOTAL    = 1'b0;
    localparam logic REG_RESERVED = 1'b1;

    localparam logic [CNT_W-1:0] TOTAL_RESET    = CNT_W'(MAX_PAGES);
    localparam logic [CNT_W-1:0] RESERVED_RESET = '0;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CNT_W-1:0]  lo;
        logic [CNT_W-1:0]  hi;
        logic [CNT_W-1:0]  lim;
        logic [PAGE_W-1:0] page;
        logic              add_ok;
        logic              free_ok;
    } wctl_t;

    typedef struct packed {
        word_t            wdata;
        word_t            cnt_bits;
        logic             hit;
        logic [BIT_W-1:0] hit_bit;
    } wres_t;

    // Bits of word w whose page number is below x.
    function automatic word_t below_mask(input logic [WIDX_W-1:0] w,
                                         input logic [CNT_W-1:0] x);
        logic [CNT_W-BIT_W-1:0] xw;
        word_t                  m;
        begin
            xw = x[CNT_W-1:BIT_W];
            if (xw > {1'b0, w}) begin
                m = '1;
            end else if (xw == {1'b0, w}) begin
                m = ~({WORD_BITS{1'b1}} << x[BIT_W-1:0]);
            end else begin
                m = '0;
            end
            return m;
        end
    endfunction

    function automatic logic [POP_W-1:0] pop_count(input word_t v);
        logic [POP_W-1:0] n;
        begin
            n = '0;
            for (int i = 0; i < WORD_BITS; i++) begin
                n = n + POP_W'(v[i]);
            end
            return n;
        end
    endfunction

endpackage
`default_nettype wire

// ----- hdl/pfba_bitmap.sv -----
// Bitmap word memory with per-word valid bits; unwritten words read as all used.
`default_nettype none
module pfba_bitmap (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         rd_en,
    input  wire logic [pfba_pkg::WIDX_W-1:0]  rd_addr,
    output pfba_pkg::word_t                   rd_data,
    input  wire logic                         wr_en,
    input  wire logic [pfba_pkg::WIDX_W-1:0]  wr_addr,
    input  wire pfba_pkg::word_t              wr_data
);

    pfba_pkg::word_t               mem [pfba_pkg::WORDS];
    logic [pfba_pkg::WORDS-1:0]    valid_reg;
    pfba_pkg::word_t               rdata_reg;
    logic                          rvalid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rvalid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : '1;

endmodule
`default_nettype wire

// ----- hdl/pfba_word_unit.sv -----
// Shared word unit: applies add, alloc or free to one bitmap word and masks it for counting.
`default_nettype none
module pfba_word_unit (
    input  wire logic [pfba_pkg::WIDX_W-1:0] word_idx,
    input  wire pfba_pkg::word_t             rdata,
    input  wire pfba_pkg::wctl_t             ctl,
    input  wire logic                        armed,
    output pfba_pkg::wres_t                  res
);

    pfba_pkg::word_t lim_mask;
    pfba_pkg::word_t range_mask;
    pfba_pkg::word_t cand;
    pfba_pkg::word_t lowest;
    pfba_pkg::word_t nword;
    logic [pfba_pkg::BIT_W-1:0] low_idx;

    always_comb begin
        lim_mask   = pfba_pkg::below_mask(word_idx, ctl.lim);
        range_mask = pfba_pkg::below_mask(word_idx, ctl.hi)
                   & ~pfba_pkg::below_mask(word_idx, ctl.lo);
        cand       = ~rdata & lim_mask;
        lowest     = cand & (~cand + pfba_pkg::word_t'(1));
        low_idx    = '0;
        for (int i = 0; i < pfba_pkg::WORD_BITS; i++) begin
            if (lowest[i]) begin
                low_idx = low_idx | pfba_pkg::BIT_W'(i);
            end
        end

        nword   = rdata;
        res.hit = 1'b0;
        unique case (ctl.op)
            pfba_pkg::OP_ADD: begin
                if (ctl.add_ok) begin
                    nword = rdata & ~range_mask;
                end
            end
            pfba_pkg::OP_ALLOC: begin
                if (armed && (cand != '0)) begin
                    nword   = rdata | lowest;
                    res.hit = 1'b1;
                end
            end
            pfba_pkg::OP_FREE: begin
                if (ctl.free_ok &&
                    (word_idx == ctl.page[pfba_pkg::PAGE_W-1:pfba_pkg::BIT_W])) begin
                    nword[ctl.page[pfba_pkg::BIT_W-1:0]] = 1'b0;
                end
            end
            default: begin
                nword = rdata;
            end
        endcase

        res.wdata    = nword;
        res.cnt_bits = ~nword & lim_mask;
        res.hit_bit  = low_idx;
    end

endmodule
`default_nettype wire

// ----- hdl/pfba_seq.sv -----
// Sequencer: range table, word sweep over the bitmap, free page count and result register.
`default_nettype none
module pfba_seq (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [pfba_pkg::OP_W-1:0]    in_op,
    input  wire logic [pfba_pkg::PAGE_W-1:0]  in_page,
    input  wire logic [pfba_pkg::CNT_W-1:0]   in_end,
    input  wire logic [pfba_pkg::CNT_W-1:0]   total_pages,
    input  wire logic [pfba_pkg::CNT_W-1:0]   reserved_low_pages,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [pfba_pkg::STAT_W-1:0]       out_status,
    output logic [pfba_pkg::PAGE_W-1:0]       out_granted,
    output logic [pfba_pkg::CNT_W-1:0]        out_free,
    output logic                              rd_en,
    output logic [pfba_pkg::WIDX_W-1:0]       rd_addr,
    input  wire pfba_pkg::word_t              rd_data,
    output logic                              wr_en,
    output logic [pfba_pkg::WIDX_W-1:0]       wr_addr,
    output pfba_pkg::word_t                   wr_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PREP  = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;

    logic [1:0]                     state_reg;
    logic [pfba_pkg::OP_W-1:0]      op_reg;
    logic [pfba_pkg::PAGE_W-1:0]    page_reg;
    logic [pfba_pkg::CNT_W-1:0]     end_reg;
    pfba_pkg::wctl_t                ctl_reg;
    logic [pfba_pkg::WIDX_W:0]      rd_ptr_reg;
    logic                           dv_reg;
    logic [pfba_pkg::WIDX_W-1:0]    dw_reg;
    logic                           cv_reg;
    pfba_pkg::word_t                cbits_reg;
    logic [pfba_pkg::CNT_W-1:0]     cnt_reg;
    logic                           found_reg;
    logic [pfba_pkg::PAGE_W-1:0]    grant_reg;
    logic [pfba_pkg::PAGE_W-1:0]    range_first_reg [pfba_pkg::MAX_RANGES];
    logic [pfba_pkg::CNT_W-1:0]     range_limit_reg [pfba_pkg::MAX_RANGES];
    logic [pfba_pkg::RCNT_W-1:0]    range_count_reg;
    logic                           out_valid_reg;
    logic [pfba_pkg::STAT_W-1:0]    out_status_reg;
    logic [pfba_pkg::PAGE_W-1:0]    out_granted_reg;
    logic [pfba_pkg::CNT_W-1:0]     out_free_reg;

    logic [pfba_pkg::CNT_W-1:0]     lim;
    logic [pfba_pkg::CNT_W-1:0]     page_ext;
    logic [pfba_pkg::CNT_W-1:0]     lo;
    logic [pfba_pkg::CNT_W-1:0]     hi;
    logic                           in_region;
    logic                           add_ok;
    logic                           accept;
    logic                           finish;
    logic [pfba_pkg::STAT_W-1:0]    status;
    pfba_pkg::wres_t                wres;

    pfba_word_unit u_word (
        .word_idx (dw_reg),
        .rdata    (rd_data),
        .ctl      (ctl_reg),
        .armed    (!found_reg),
        .res      (wres)
    );

    always_comb begin
        lim      = (total_pages > pfba_pkg::CNT_W'(pfba_pkg::MAX_PAGES))
                 ? pfba_pkg::CNT_W'(pfba_pkg::MAX_PAGES) : total_pages;
        page_ext = {1'b0, page_reg};
        lo       = (page_ext < reserved_low_pages) ? reserved_low_pages : page_ext;
        hi       = (end_reg < lim) ? end_reg : lim;
        add_ok   = range_count_reg < pfba_pkg::RCNT_W'(pfba_pkg::MAX_RANGES);
        in_region = 1'b0;
        for (int i = 0; i < pfba_pkg::MAX_RANGES; i++) begin
            if ((pfba_pkg::RCNT_W'(i) < range_count_reg) &&
                (page_reg >= range_first_reg[i]) &&
                (page_ext < range_limit_reg[i])) begin
                in_region = 1'b1;
            end
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign rd_en    = (state_reg == S_PREP) ||
                      ((state_reg == S_SWEEP) && !rd_ptr_reg[pfba_pkg::WIDX_W]);
    assign rd_addr  = rd_ptr_reg[pfba_pkg::WIDX_W-1:0];
    assign wr_en    = dv_reg;
    assign wr_addr  = dw_reg;
    assign wr_data  = wres.wdata;
    assign finish   = (state_reg == S_SWEEP) && rd_ptr_reg[pfba_pkg::WIDX_W] &&
                      !dv_reg && !cv_reg && (!out_valid_reg || out_ready);

    always_comb begin
        unique case (ctl_reg.op)
            pfba_pkg::OP_ADD:   status = ctl_reg.add_ok ? pfba_pkg::ST_DONE : pfba_pkg::ST_FULL;
            pfba_pkg::OP_ALLOC: status = found_reg ? pfba_pkg::ST_DONE : pfba_pkg::ST_FAIL;
            pfba_pkg::OP_FREE:  status = ctl_reg.free_ok ? pfba_pkg::ST_DONE : pfba_pkg::ST_FAIL;
            default:            status = pfba_pkg::ST_FAIL;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= in_op;
            page_reg <= in_page;
            end_reg  <= in_end;
        end
        if (state_reg == S_PREP) begin
            ctl_reg.op      <= op_reg;
            ctl_reg.lo      <= lo;
            ctl_reg.hi      <= hi;
            ctl_reg.lim     <= lim;
            ctl_reg.page    <= page_reg;
            ctl_reg.add_ok  <= add_ok;
            ctl_reg.free_ok <= (page_ext < lim) && in_region;
            if ((op_reg == pfba_pkg::OP_ADD) && add_ok) begin
                range_first_reg[range_count_reg[pfba_pkg::RIDX_W-1:0]] <= page_reg;
                range_limit_reg[range_count_reg[pfba_pkg::RIDX_W-1:0]] <= end_reg;
            end
        end
        dw_reg    <= rd_addr;
        cbits_reg <= wres.cnt_bits;
        if (dv_reg && wres.hit) begin
            grant_reg <= {dw_reg, wres.hit_bit};
        end
        if (finish) begin
            out_status_reg  <= status;
            out_granted_reg <= found_reg ? grant_reg : '0;
            out_free_reg    <= cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            rd_ptr_reg      <= '0;
            dv_reg          <= 1'b0;
            cv_reg          <= 1'b0;
            cnt_reg         <= '0;
            found_reg       <= 1'b0;
            range_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            dv_reg <= rd_en;
            cv_reg <= dv_reg;
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + (pfba_pkg::WIDX_W+1)'(1);
            end
            if (cv_reg) begin
                cnt_reg <= cnt_reg + pfba_pkg::CNT_W'(pfba_pkg::pop_count(cbits_reg));
            end
            if (dv_reg && wres.hit) begin
                found_reg <= 1'b1;
            end
            if (finish) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        rd_ptr_reg <= '0;
                        cnt_reg    <= '0;
                        found_reg  <= 1'b0;
                        state_reg  <= S_PREP;
                    end
                end
                S_PREP: begin
                    if ((op_reg == pfba_pkg::OP_ADD) && add_ok) begin
                        range_count_reg <= range_count_reg + pfba_pkg::RCNT_W'(1);
                    end
                    state_reg <= S_SWEEP;
                end
                S_SWEEP: begin
                    if (finish) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_granted = out_granted_reg;
    assign out_free    = out_free_reg;

endmodule
`default_nettype wire

// ----- hdl/page_frame_bitmap_allocator_top.sv -----
// Top level of the page frame bitmap allocator: stream ports, APB registers, bitmap and sequencer.
//
// Usage:
//   s_ channel carries one request word: operation (add range, alloc, free), a page number
//   and, for add range, the exclusive end page. m_ channel returns one result word per
//   request: status, granted page and the number of free pages below total_pages.
//   APB registers: total_pages at 0x0, reserved_low_pages at 0x4. Write them only while
//   no request is in flight.
//   Every request sweeps all 128 bitmap words through one read-modify-write word unit on
//   a single-port-read memory: 128 word reads (the first in the setup state), then the
//   dv and cv stages drain and the result register is loaded; m_tvalid rises and s_tready
//   returns in the same cycle. One request is handled at a time.
//   Reset marks every page used, empties the range table and restores the registers
//   (total_pages 4096, reserved_low_pages 0). No clearing pass is needed.
//   The result sits in an output register; the next request may be taken while it waits.
//   If m_tready stays low, the following request stalls at its end until the result is taken.
`default_nettype none
module page_frame_bitmap_allocator_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [31:0]                   s_tdata,  // operation, page_number, range_end_page
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [31:0]                        m_tdata,  // status, granted_page, free_pages
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pfba_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int IN_PAGE_LO = pfba_pkg::OP_W;
    localparam int IN_END_LO  = IN_PAGE_LO + pfba_pkg::PAGE_W;
    localparam int IN_BITS    = IN_END_LO + pfba_pkg::CNT_W;
    localparam int OUT_BITS   = pfba_pkg::STAT_W + pfba_pkg::PAGE_W + pfba_pkg::CNT_W;

    logic [pfba_pkg::CNT_W-1:0]   total_reg;
    logic [pfba_pkg::CNT_W-1:0]   reserved_reg;
    logic                         cfg_wr;
    logic [pfba_pkg::STAT_W-1:0]  out_status;
    logic [pfba_pkg::PAGE_W-1:0]  out_granted;
    logic [pfba_pkg::CNT_W-1:0]   out_free;
    logic                         rd_en;
    logic [pfba_pkg::WIDX_W-1:0]  rd_addr;
    pfba_pkg::word_t              rd_data;
    logic                         wr_en;
    logic [pfba_pkg::WIDX_W-1:0]  wr_addr;
    pfba_pkg::word_t              wr_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg    <= pfba_pkg::TOTAL_RESET;
            reserved_reg <= pfba_pkg::RESERVED_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == pfba_pkg::REG_RESERVED) begin
                reserved_reg <= pwdata[pfba_pkg::CNT_W-1:0];
            end else begin
                total_reg <= pwdata[pfba_pkg::CNT_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == pfba_pkg::REG_RESERVED)
                  ? {{(32-pfba_pkg::CNT_W){1'b0}}, reserved_reg}
                  : {{(32-pfba_pkg::CNT_W){1'b0}}, total_reg};

    pfba_bitmap u_bitmap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    pfba_seq u_seq (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .in_valid           (s_tvalid),
        .in_ready           (s_tready),
        .in_op              (s_tdata[pfba_pkg::OP_W-1:0]),
        .in_page            (s_tdata[IN_END_LO-1:IN_PAGE_LO]),
        .in_end             (s_tdata[IN_BITS-1:IN_END_LO]),
        .total_pages        (total_reg),
        .reserved_low_pages (reserved_reg),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .out_status         (out_status),
        .out_granted        (out_granted),
        .out_free           (out_free),
        .rd_en              (rd_en),
        .rd_addr            (rd_addr),
        .rd_data            (rd_data),
        .wr_en              (wr_en),
        .wr_addr            (wr_addr),
        .wr_data            (wr_data)
    );

    assign m_tdata = {{(32-OUT_BITS){1'b0}}, out_free, out_granted, out_status};

endmodule
`default_nettype wire

// ----- hdl/pfba_checker.sv -----
// Port-level checker for the page frame bitmap allocator, bound to the top level.
`default_nettype none
module pfba_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while another is in progress");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (((m_tdata[1:0] == pfba_pkg::ST_DONE) ||
                       (m_tdata[1:0] == pfba_pkg::ST_FAIL) ||
                       (m_tdata[1:0] == pfba_pkg::ST_FULL)) &&
                      (m_tdata[31:27] == 5'd0)))
        else $error("bad status code or padding");

    a_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] != pfba_pkg::ST_DONE)) |-> (m_tdata[13:2] == 12'd0))
        else $error("granted page set on failed request");

    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[26:14] <= 13'(pfba_pkg::MAX_PAGES)))
        else $error("free page count out of range");

endmodule

bind page_frame_bitmap_allocator_top pfba_checker u_pfba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
